>>> rtl/stls_pkg.sv
// Package for the sorted-table leftmost search unit.
// Holds widths, field offsets, opcodes and the controller/datapath records.
// Used by every module of the rtl folder except stls_ram.
`default_nettype none

package stls_pkg;

  // Table depth, a power of two; indices wrap modulo the depth.
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned TABLE_AW    = $clog2(TABLE_DEPTH);

  localparam int unsigned IDX_W = 8;
  localparam int unsigned VAL_W = 32;

  // Slave tdata layout, lowest bit first.
  localparam int unsigned ENTRY_INDEX_LSB = 0;
  localparam int unsigned ENTRY_VALUE_LSB = ENTRY_INDEX_LSB + IDX_W;
  localparam int unsigned SEARCH_KEY_LSB  = ENTRY_VALUE_LSB + VAL_W;
  localparam int unsigned RANGE_LOW_LSB   = SEARCH_KEY_LSB + VAL_W;
  localparam int unsigned RANGE_HIGH_LSB  = RANGE_LOW_LSB + IDX_W;
  localparam int unsigned S_FIELDS_W      = RANGE_HIGH_LSB + IDX_W;
  localparam int unsigned S_TDATA_W       = ((S_FIELDS_W + 7) / 8) * 8;

  // Master tdata layout, lowest bit first.
  localparam int unsigned FOUND_LSB    = 0;
  localparam int unsigned POSITION_LSB = FOUND_LSB + 1;
  localparam int unsigned M_FIELDS_W   = POSITION_LSB + IDX_W;
  localparam int unsigned M_TDATA_W    = ((M_FIELDS_W + 7) / 8) * 8;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } opcode_e;

  typedef struct packed {
    logic write;  // store one table entry
    logic load;   // start a search, issue the first probe
    logic step;   // consume probe data, advance the range
    logic emit;   // move the result into the output register
  } stls_cmd_t;

  typedef struct packed {
    logic empty;       // range_high below range_low on the incoming request
    logic last_probe;  // data now returning belongs to the final probe
  } stls_sts_t;

  function automatic logic [TABLE_AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[TABLE_AW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/stls_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module stls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/stls_ctrl.sv
// Controller state machine of the search unit: request and result handshakes.
// Depends on stls_pkg; drives stls_dpath through command records.
`default_nettype none

module stls_ctrl
  import stls_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      s_tvalid_i,
  input  wire logic      s_tuser_i,
  output logic           s_tready_o,
  output logic           m_tvalid_o,
  input  wire logic      m_tready_i,
  output stls_cmd_t      cmd_o,
  input  wire stls_sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;
  logic   accept;
  logic   out_free;

  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i & s_tready_o;
  assign out_free   = ~m_valid_q | m_tready_i;

  always_comb begin
    state_d      = state_q;
    m_valid_d    = m_valid_q & ~m_tready_i;
    cmd_o        = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (opcode_e'(s_tuser_i) == OP_SEARCH) begin
            cmd_o.load = 1'b1;
            state_d    = sts_i.empty ? ST_EMIT : ST_LOOK;
          end else begin
            cmd_o.write = 1'b1;
          end
        end
      end
      ST_LOOK: begin
        cmd_o.step = 1'b1;
        if (sts_i.last_probe) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          m_valid_d  = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_tvalid_o = m_valid_q;

endmodule

`default_nettype wire

>>> rtl/stls_dpath.sv
// Datapath of the search unit: range registers, probe address, table RAM, result.
// Depends on stls_pkg and stls_ram; steered by stls_ctrl.
`default_nettype none

module stls_dpath
  import stls_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire stls_cmd_t            cmd_i,
  output stls_sts_t                 sts_o,
  input  wire logic [S_TDATA_W-1:0] s_tdata_i,
  output logic      [M_TDATA_W-1:0] m_tdata_o
);

  logic [IDX_W-1:0]        in_index, in_low, in_high;
  logic signed [VAL_W-1:0] in_value, in_key;

  logic [IDX_W-1:0]        low_q, high_q, mid_q;
  logic signed [VAL_W-1:0] key_q;
  logic                    final_q;
  logic                    found_q, out_found_q;
  logic [IDX_W-1:0]        pos_q, out_pos_q;

  logic signed [VAL_W-1:0] rdata;
  logic                    less;
  logic [IDX_W-1:0]        lo_n, hi_n, probe;
  logic [IDX_W:0]          sum;
  logic                    final_n;
  logic                    rd_en;

  assign in_index = s_tdata_i[ENTRY_INDEX_LSB +: IDX_W];
  assign in_value = s_tdata_i[ENTRY_VALUE_LSB +: VAL_W];
  assign in_key   = s_tdata_i[SEARCH_KEY_LSB  +: VAL_W];
  assign in_low   = s_tdata_i[RANGE_LOW_LSB   +: IDX_W];
  assign in_high  = s_tdata_i[RANGE_HIGH_LSB  +: IDX_W];

  assign less = rdata < key_q;

  always_comb begin
    if (cmd_i.load) begin
      lo_n = in_low;
      hi_n = in_high;
    end else if (less) begin
      lo_n = mid_q + IDX_W'(1);
      hi_n = high_q;
    end else begin
      lo_n = low_q;
      hi_n = mid_q;
    end
    sum     = {1'b0, lo_n} + {1'b0, hi_n};
    final_n = ~(lo_n < hi_n);
    probe   = final_n ? lo_n : sum[IDX_W:1];
  end

  assign rd_en = cmd_i.load | (cmd_i.step & ~final_q);

  stls_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write),
    .waddr_i (to_addr(in_index)),
    .wdata_i (in_value),
    .re_i    (rd_en),
    .raddr_i (to_addr(probe)),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q   <= in_key;
      found_q <= 1'b0;
      pos_q   <= '0;
    end
    if (rd_en) begin
      low_q   <= lo_n;
      high_q  <= hi_n;
      mid_q   <= probe;
      final_q <= final_n;
    end
    if (cmd_i.step & final_q) begin
      found_q <= (rdata == key_q);
      pos_q   <= (rdata == key_q) ? mid_q : '0;
    end
    if (cmd_i.emit) begin
      out_found_q <= found_q;
      out_pos_q   <= pos_q;
    end
  end

  assign sts_o.empty      = in_high < in_low;
  assign sts_o.last_probe = final_q;

  assign m_tdata_o = M_TDATA_W'({out_pos_q, out_found_q});

endmodule

`default_nettype wire

>>> rtl/sorted_table_leftmost_search_unit.sv
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tuser: opcode; tdata: entry_index, entry_value, search_key,
//                range_low, range_high
// m_axis    out  tdata: found, position, zero fill to 16 bits
//
// A write request stores one entry and gives no result.
// A search probes the table once per halving of the range, then once more for
// the final compare, and then loads the output register; the probe loop runs
// around the single read port of the table RAM.
// Reset clears control only; table contents stay undefined until written.
// A result waits in the output register while the next request is taken; a
// search finishing meanwhile holds until that register is free.
// Depends on stls_pkg, stls_ctrl, stls_dpath.
`default_nettype none

module sorted_table_leftmost_search_unit
  import stls_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // entry_index, entry_value,
                                                   // search_key, range_low, range_high
  input  wire logic                 s_axis_tuser,  // opcode
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic      [M_TDATA_W-1:0] m_axis_tdata   // found, position, zero fill
);

  stls_cmd_t cmd;
  stls_sts_t sts;

  stls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tuser_i  (s_axis_tuser),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  stls_dpath u_dpath (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .s_tdata_i (s_axis_tdata),
    .m_tdata_o (m_axis_tdata)
  );

endmodule

`default_nettype wire

>>> rtl/stls_checker.sv
// Port-level checks for the search unit, bound to the top level.
// Depends on stls_pkg and sorted_table_leftmost_search_unit.
`default_nettype none

module stls_checker
  import stls_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic                 s_axis_tuser,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata
);

  logic s_acc;
  assign s_acc = s_axis_tvalid & s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser == OP_WRITE) && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("write request produced a result");

  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser == OP_SEARCH) |=> !s_axis_tready)
    else $error("request taken while a search runs");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[FOUND_LSB] |->
      m_axis_tdata[POSITION_LSB +: IDX_W] == '0)
    else $error("position not zero on a miss");

endmodule

bind sorted_table_leftmost_search_unit stls_checker u_stls_checker (.*);

`default_nettype wire

>>> dv/tb.sv
// Testbench for sorted_table_leftmost_search_unit: streams write and search requests,
// predicts each search with its own table copy and checks every result in order.
// Depends on stls_pkg and the unit under test.
`timescale 1ns / 1ps

module tb;
  import stls_pkg::*;

  localparam int unsigned N_ITEMS = 850;

  typedef struct {
    opcode_e           op;
    logic [IDX_W-1:0]  entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] search_key;
    logic [IDX_W-1:0]  range_low;
    logic [IDX_W-1:0]  range_high;
  } request_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
  } search_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;   // entry_index, entry_value, search_key,
                                        // range_low, range_high
  logic                 s_axis_tuser;   // opcode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;   // found, position, zero fill

  request_t           request_q[$];
  search_result_t     answer_q[$];
  request_t           cur_req;
  logic signed [31:0] table_model [TABLE_DEPTH];
  logic signed [31:0] gen_table [TABLE_DEPTH];
  int unsigned        sent_cnt;
  int unsigned        total_items;
  int unsigned        err_cnt;
  int unsigned        hold_cnt;
  bit                 hold_done;

  sorted_table_leftmost_search_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic search_result_t predict_search(logic signed [31:0] key,
                                                    logic [IDX_W-1:0] lo,
                                                    logic [IDX_W-1:0] hi);
    int unsigned    l;
    int unsigned    h;
    int unsigned    mid;
    search_result_t r;
    r = '0;
    if (hi >= lo) begin
      l = 32'(lo);
      h = 32'(hi);
      while (l < h) begin
        mid = (l + h) >> 1;
        if (table_model[mid % TABLE_DEPTH] < key) l = mid + 1;
        else h = mid;
      end
      if (table_model[l % TABLE_DEPTH] == key) begin
        r.found    = 1'b1;
        r.position = l[IDX_W-1:0];
      end
    end
    return r;
  endfunction

  task automatic push_write(int unsigned idx, logic signed [31:0] val);
    request_t r;
    r.op          = OP_WRITE;
    r.entry_index = idx[IDX_W-1:0];
    r.entry_value = val;
    r.search_key  = $urandom();
    r.range_low   = IDX_W'($urandom_range(0, 255));
    r.range_high  = IDX_W'($urandom_range(0, 255));
    gen_table[idx % TABLE_DEPTH] = val;
    request_q.push_back(r);
  endtask

  task automatic push_search(logic signed [31:0] key, int unsigned lo, int unsigned hi);
    request_t r;
    r.op          = OP_SEARCH;
    r.entry_index = IDX_W'($urandom_range(0, 255));
    r.entry_value = $urandom();
    r.search_key  = key;
    r.range_low   = lo[IDX_W-1:0];
    r.range_high  = hi[IDX_W-1:0];
    request_q.push_back(r);
  endtask

  function automatic logic signed [31:0] pick_key(int unsigned lo, int unsigned hi);
    logic signed [31:0] v;
    v = gen_table[$urandom_range(lo, hi)];
    case ($urandom_range(0, 4))
      0: return v + 1;
      1: return v - 1;
      2: return $urandom();
      default: return v;
    endcase
  endfunction

  // Stimulus and end of run
  initial begin
    int unsigned i;
    int unsigned a;
    int unsigned b;
    int unsigned lo;
    int unsigned hi;
    int unsigned seg_lo;
    int unsigned seg_hi;
    longint      v;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    sent_cnt      = 0;
    err_cnt       = 0;
    hold_cnt      = 0;
    hold_done     = 1'b0;

    // directed: sorted run with duplicates and both extremes
    push_write(0, 32'sh8000_0000);
    push_write(1, -5);
    push_write(2, -5);
    push_write(3, 0);
    push_write(4, 7);
    push_write(5, 7);
    push_write(6, 7);
    push_write(7, 32'sh7fff_ffff);
    push_write(254, 100);
    push_write(255, 32'sh7fff_ffff);
    push_search(-5, 0, 7);
    push_search(7, 0, 7);
    push_search(32'sh8000_0000, 0, 7);
    push_search(32'sh7fff_ffff, 0, 7);
    push_search(3, 0, 7);
    push_search(7, 5, 6);
    push_search(32'sh7fff_ffff, 255, 255);
    push_search(100, 254, 255);
    push_search(32'sh8000_0000, 0, 0);
    push_search(7, 255, 0);
    push_search(7, 5, 4);
    // unsorted tail
    push_write(8, -100);
    push_search(-100, 0, 8);

    // fill the whole table ascending
    v = -64'sd2147483648;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      push_write(i, v[31:0]);
      if ($urandom_range(0, 3) != 0) v += longint'($urandom_range(0, 1 << 24));
      if (v > 64'sd2147483647) v = 64'sd2147483647;
    end
    seg_lo = 0;
    seg_hi = TABLE_DEPTH - 1;

    while (request_q.size() < N_ITEMS) begin
      case ($urandom_range(0, 99)) inside
        [0:29]: begin
          a = $urandom_range(0, 255);
          b = a + $urandom_range(0, 15);
          if (b > 255) b = 255;
          case ($urandom_range(0, 3))
            0: v = -64'sd2147483648;
            1: v = 64'sd2147483647 - longint'($urandom_range(0, 40));
            2: v = longint'($signed($urandom_range(0, 200))) - 100;
            default: v = longint'($signed($urandom()));
          endcase
          for (i = a; i <= b; i++) begin
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            push_write(i, v[31:0]);
            if ($urandom_range(0, 2) != 0)
              v += longint'($urandom_range(1, 1 << $urandom_range(0, 20)));
          end
          seg_lo = a;
          seg_hi = b;
        end
        [30:79]: begin
          lo = $urandom_range(seg_lo, seg_hi);
          hi = $urandom_range(lo, seg_hi);
          push_search(pick_key(lo, hi), lo, hi);
        end
        [80:89]: begin
          if ($urandom_range(0, 3) == 0) begin
            lo = 0;
            hi = 255;
          end else begin
            lo = $urandom_range(0, 255);
            hi = $urandom_range(lo, 255);
          end
          push_search(pick_key(lo, hi), lo, hi);
        end
        [90:95]: begin
          lo = $urandom_range(1, 255);
          hi = $urandom_range(0, lo - 1);
          push_search($urandom(), lo, hi);
        end
        default: push_write($urandom_range(0, 255), $urandom());
      endcase
    end
    total_items = request_q.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sent_cnt < total_items) @(posedge clk_i);
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (err_cnt == 0 && answer_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int unsigned stage_of(int unsigned n);
    return (n / 100) % 4;
  endfunction

  // Request driver
  always @(posedge clk_i) begin
    int unsigned idle_pct;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (cur_req.op == OP_WRITE) begin
          table_model[cur_req.entry_index % TABLE_DEPTH] = cur_req.entry_value;
        end else begin
          answer_q.push_back(predict_search(cur_req.search_key, cur_req.range_low,
                                            cur_req.range_high));
        end
        sent_cnt <= sent_cnt + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        case (stage_of(sent_cnt))
          1: idle_pct = 65;
          3: idle_pct = 20;
          default: idle_pct = 0;
        endcase
        if (request_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          cur_req = request_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cur_req.op;
          s_axis_tdata  <= S_TDATA_W'({cur_req.range_high, cur_req.range_low,
                                       cur_req.search_key, cur_req.entry_value,
                                       cur_req.entry_index});
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    int unsigned stall_pct;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt = hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && sent_cnt >= 400) begin
      hold_done = 1'b1;
      hold_cnt  = 300;
      m_axis_tready <= 1'b0;
    end else begin
      case (stage_of(sent_cnt))
        2: stall_pct = 65;
        3: stall_pct = 20;
        default: stall_pct = 0;
      endcase
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    search_result_t exp_r;
    search_result_t got_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_r.found    = m_axis_tdata[FOUND_LSB];
      got_r.position = m_axis_tdata[POSITION_LSB +: IDX_W];
      if (answer_q.size() == 0) begin
        err_cnt = err_cnt + 1;
        if (err_cnt <= 10)
          $display("unexpected result: found=%0b position=%0d", got_r.found, got_r.position);
      end else begin
        exp_r = answer_q.pop_front();
        if (got_r.found !== exp_r.found || got_r.position !== exp_r.position) begin
          err_cnt = err_cnt + 1;
          if (err_cnt <= 10)
            $display("mismatch: expected found=%0b position=%0d, got found=%0b position=%0d",
                     exp_r.found, exp_r.position, got_r.found, got_r.position);
        end
      end
    end
  end

endmodule
